// ===== design/eqc_pkg.sv =====
// Shared types, constants and board functions for the eight queens completion search.
// No dependencies; every design file refers to this package by scoped names.
package eqc_pkg;

  localparam int BOARD_SIZE_DEF = 8;   // default board edge length
  localparam int STRIDE         = 8;   // bit distance between rows
  localparam int NUM_SQ         = STRIDE * STRIDE;
  localparam int SQ_W           = 6;   // square index width
  localparam int NEXT_W         = SQ_W + 1;  // scan start, may reach NUM_SQ
  localparam int STACK_DEPTH    = 8;
  localparam int LVL_W          = 3;
  localparam int CNT_W          = 4;   // queen count, saturates at 15

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result of one pass of the scan unit
  typedef struct packed {
    logic              found;
    logic [SQ_W-1:0]   square;
    logic [NUM_SQ-1:0] attack;
  } eqc_scan_res_t;

  // Write request into the search stack
  typedef struct packed {
    logic              we;
    logic [LVL_W-1:0]  idx;
    logic [NUM_SQ-1:0] blocked;
    logic [SQ_W-1:0]   square;
  } eqc_stack_wr_t;

  // Squares whose row and column both lie below the board size
  function automatic logic [NUM_SQ-1:0] on_board_mask(input int n);
    logic [NUM_SQ-1:0] m;
    logic [2:0]        i;
    logic [2:0]        j;
    m = '0;
    for (int k = 0; k < NUM_SQ; k++) begin
      i = k[5:3];
      j = k[2:0];
      m[k] = (int'(i) < n) && (int'(j) < n);
    end
    return m;
  endfunction

  // Squares attacked by a queen on sq: own row, column and both diagonals
  function automatic logic [NUM_SQ-1:0] attack_mask(input int n, input logic [SQ_W-1:0] sq);
    logic [NUM_SQ-1:0] m;
    logic [2:0]        r;
    logic [2:0]        c;
    logic [2:0]        i;
    logic [2:0]        j;
    r = sq[5:3];
    c = sq[2:0];
    m = '0;
    for (int k = 0; k < NUM_SQ; k++) begin
      i = k[5:3];
      j = k[2:0];
      m[k] = (int'(i) < n) && (int'(j) < n) &&
             ((i == r) || (j == c) ||
              ({1'b0, i} + {1'b0, c} == {1'b0, r} + {1'b0, j}) ||
              ({1'b0, i} + {1'b0, j} == {1'b0, r} + {1'b0, c}));
    end
    return m;
  endfunction

endpackage

// ===== design/eqc_scan_unit.sv =====
// Shared scan unit: finds the first candidate square at or after a start index
// and gives the attack mask of that square. Depends on eqc_pkg.
module eqc_scan_unit #(
  parameter int BOARD_SIZE = eqc_pkg::BOARD_SIZE_DEF
) (
  input  logic [eqc_pkg::NUM_SQ-1:0] cand_i,
  input  logic [eqc_pkg::NEXT_W-1:0] start_i,
  output eqc_pkg::eqc_scan_res_t     res_o
);

  logic [eqc_pkg::NUM_SQ-1:0] live;
  logic [eqc_pkg::SQ_W-1:0]   first_sq;

  // Drop candidates below the start index
  always_comb begin
    for (int k = 0; k < eqc_pkg::NUM_SQ; k++) begin
      live[k] = cand_i[k] && (eqc_pkg::NEXT_W'(k) >= start_i);
    end
  end

  // Priority encode the lowest remaining candidate
  always_comb begin
    first_sq = '0;
    for (int k = eqc_pkg::NUM_SQ - 1; k >= 0; k--) begin
      if (live[k]) begin
        first_sq = eqc_pkg::SQ_W'(k);
      end
    end
  end

  assign res_o.found  = |live;
  assign res_o.square = first_sq;
  assign res_o.attack = eqc_pkg::attack_mask(BOARD_SIZE, first_sq);

endmodule

// ===== design/eqc_stack.sv =====
// Search stack: blocked mask and chosen square for each search level.
// Depends on eqc_pkg. Contents are undefined until written.
module eqc_stack (
  input  logic                       clk_i,
  input  eqc_pkg::eqc_stack_wr_t     wr_i,
  input  logic [eqc_pkg::LVL_W-1:0]  rd_idx_i,
  output logic [eqc_pkg::NUM_SQ-1:0] rd_blocked_o,
  output logic [eqc_pkg::SQ_W-1:0]   rd_square_o
);

  logic [eqc_pkg::NUM_SQ-1:0] blocked_stack_q [eqc_pkg::STACK_DEPTH];
  logic [eqc_pkg::SQ_W-1:0]   square_stack_q  [eqc_pkg::STACK_DEPTH];

  // Store one level per write request
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      blocked_stack_q[wr_i.idx] <= wr_i.blocked;
      square_stack_q[wr_i.idx]  <= wr_i.square;
    end
  end

  assign rd_blocked_o = blocked_stack_q[rd_idx_i];
  assign rd_square_o  = square_stack_q[rd_idx_i];

endmodule

// ===== design/eight_queens_completion_search.sv =====
// Eight queens completion search: one request of preset queens in, one solvable bit out.
// Sequence: fold each on-board preset queen into the blocked mask, decide, then run the
// depth-first search by placement and backtrack steps, at most two per non-attacking partial placement
// (data dependent). One request at a time: ready is low until result is taken.
// Reset returns the sequencer to idle and drops any pending result; the stack needs no clear.
// Depends on eqc_pkg, eqc_scan_unit and eqc_stack.
module eight_queens_completion_search #(
  parameter int BOARD_SIZE = eqc_pkg::BOARD_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] preset_queens_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        solvable_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COUNT  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [eqc_pkg::NUM_SQ-1:0] OnBoard = eqc_pkg::on_board_mask(BOARD_SIZE);
  localparam logic [eqc_pkg::CNT_W-1:0]  BoardN  = eqc_pkg::CNT_W'(BOARD_SIZE);

  logic [2:0]                  state_q, state_d;
  logic                        valid_q, valid_d;
  logic                        solvable_q, solvable_d;
  logic [eqc_pkg::CNT_W-1:0]   placed_count_q, placed_count_d;
  logic [eqc_pkg::LVL_W-1:0]   level_q, level_d;
  logic [eqc_pkg::CNT_W-1:0]   need_q, need_d;
  logic [eqc_pkg::NEXT_W-1:0]  next_q, next_d;
  logic [eqc_pkg::NUM_SQ-1:0]  board_q, board_d;
  logic [eqc_pkg::NUM_SQ-1:0]  cur_q, cur_d;

  logic [eqc_pkg::NUM_SQ-1:0]  scan_cand;
  eqc_pkg::eqc_scan_res_t      scan_res;
  eqc_pkg::eqc_stack_wr_t      stk_wr;
  logic [eqc_pkg::LVL_W-1:0]   stk_rd_idx;
  logic [eqc_pkg::NUM_SQ-1:0]  stk_blocked;
  logic [eqc_pkg::SQ_W-1:0]    stk_square;
  logic [eqc_pkg::NEXT_W-1:0]  found_next;
  logic [eqc_pkg::CNT_W-1:0]   level_inc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;
  assign solvable_o  = solvable_q;

  // Presets while counting, free squares while searching
  assign scan_cand = (state_q == ST_COUNT) ? board_q : (~cur_q & OnBoard);

  eqc_scan_unit #(
    .BOARD_SIZE(BOARD_SIZE)
  ) u_scan (
    .cand_i (scan_cand),
    .start_i(next_q),
    .res_o  (scan_res)
  );

  assign stk_rd_idx = level_q - eqc_pkg::LVL_W'(1);

  eqc_stack u_stack (
    .clk_i       (clk_i),
    .wr_i        (stk_wr),
    .rd_idx_i    (stk_rd_idx),
    .rd_blocked_o(stk_blocked),
    .rd_square_o (stk_square)
  );

  assign found_next = {1'b0, scan_res.square} + eqc_pkg::NEXT_W'(1);
  assign level_inc  = {1'b0, level_q} + eqc_pkg::CNT_W'(1);

  // Sequence counting, decision and depth-first search
  always_comb begin
    state_d        = state_q;
    valid_d        = valid_q;
    solvable_d     = solvable_q;
    placed_count_d = placed_count_q;
    level_d        = level_q;
    need_d         = need_q;
    next_d         = next_q;
    board_d        = board_q;
    cur_d          = cur_q;
    stk_wr.we      = 1'b0;
    stk_wr.idx     = level_q;
    stk_wr.blocked = cur_q;
    stk_wr.square  = scan_res.square;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          board_d        = preset_queens_i & OnBoard;
          cur_d          = '0;
          next_d         = '0;
          placed_count_d = '0;
          level_d        = '0;
          state_d        = ST_COUNT;
        end
      end
      ST_COUNT: begin
        // Fold one preset queen per cycle into the blocked mask
        if (scan_res.found) begin
          if (placed_count_q != eqc_pkg::CNT_MAX) begin
            placed_count_d = placed_count_q + eqc_pkg::CNT_W'(1);
          end
          cur_d  = cur_q | scan_res.attack;
          next_d = found_next;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (placed_count_q > BoardN) begin
          solvable_d = 1'b0;
          valid_d    = 1'b1;
          state_d    = ST_DONE;
        end else if (placed_count_q == BoardN) begin
          solvable_d = 1'b1;
          valid_d    = 1'b1;
          state_d    = ST_DONE;
        end else begin
          need_d  = BoardN - placed_count_q;
          level_d = '0;
          next_d  = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (scan_res.found) begin
          // Place a queen: finish, or push this level and descend
          stk_wr.we = 1'b1;
          if (level_inc >= need_q) begin
            solvable_d = 1'b1;
            valid_d    = 1'b1;
            state_d    = ST_DONE;
          end else begin
            cur_d   = cur_q | scan_res.attack;
            level_d = level_q + eqc_pkg::LVL_W'(1);
            next_d  = found_next;
          end
        end else if (level_q == '0) begin
          solvable_d = 1'b0;
          valid_d    = 1'b1;
          state_d    = ST_DONE;
        end else begin
          // Backtrack: restore the parent mask, resume after its square
          level_d = stk_rd_idx;
          cur_d   = stk_blocked;
          next_d  = {1'b0, stk_square} + eqc_pkg::NEXT_W'(1);
        end
      end
      ST_DONE: begin
        // Hold the result until taken
        if (out_ready_i) begin
          valid_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        valid_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      valid_q        <= 1'b0;
      placed_count_q <= '0;
      level_q        <= '0;
    end else begin
      state_q        <= state_d;
      valid_q        <= valid_d;
      placed_count_q <= placed_count_d;
      level_q        <= level_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    solvable_q <= solvable_d;
    need_q     <= need_d;
    next_q     <= next_d;
    board_q    <= board_d;
    cur_q      <= cur_d;
  end

endmodule

// ===== test/eight_queens_completion_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for eight_queens_completion_search: queued boards in, solvable bit out.
// Carries its own depth-first completion predictor; depends on the design files only.
module eight_queens_completion_search_test;

  localparam int BOARD      = 8;
  localparam int EDGE_W     = 8;        // bit distance between rows on the port
  localparam int RAND_ITEMS = 119;
  localparam int TAIL_ITEMS = 25;       // last requests run with no idling
  localparam int LONG_HOLD  = 600;      // receiver hold-off, in cycles
  localparam int HOLD_AT    = 30;       // results seen before the hold-off starts
  localparam int END_WAIT   = 64;
  localparam int CYCLE_CAP  = 200_000_000;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    logic [63:0] board;
    bit          drain_first;           // wait for every result before sending
  } board_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] preset_queens = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        solvable;

  board_req_t board_queue[$];
  bit         solvable_expected[$];
  int         total_boards = 0;
  int         accepted_count = 0;
  int         results_seen = 0;
  int         solvable_seen = 0;
  int         mismatch_count = 0;
  int         orphan_count = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_cycles = 0;
  bit         hold_done = 1'b0;
  int         cycle_count = 0;

  eight_queens_completion_search u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .preset_queens_i(preset_queens),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .solvable_o     (solvable)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Squares a queen on (r, c) covers: its own, its row, its column, both diagonals
  function automatic logic [63:0] threat_mask(input int r, input int c);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < BOARD; i++) begin
      for (int j = 0; j < BOARD; j++) begin
        if (i == r || j == c || (i - r) == (j - c) || (i - r) == (c - j))
          m[i*EDGE_W+j] = 1'b1;
      end
    end
    return m;
  endfunction

  // Depth-first search for a completion to BOARD queens, scanning squares in order
  function automatic bit board_completable(input logic [63:0] board);
    logic [63:0] blocked [BOARD];
    int          pick [BOARD];
    logic [63:0] base;
    int          count;
    int          need;
    int          depth;
    int          scan;
    int          hit;
    bit          answer;
    bit          searching;
    base  = '0;
    count = 0;
    for (int r = 0; r < BOARD; r++) begin
      for (int c = 0; c < BOARD; c++) begin
        if (board[r*EDGE_W+c]) begin
          count++;
          base |= threat_mask(r, c);
        end
      end
    end
    if (count > BOARD) return 1'b0;
    need = BOARD - count;
    if (need == 0) return 1'b1;
    blocked[0] = base;
    depth      = 0;
    scan       = 0;
    answer     = 1'b0;
    searching  = 1'b1;
    while (searching) begin
      hit = -1;
      for (int sq = scan; sq < 64 && hit < 0; sq++) begin
        if (sq / EDGE_W < BOARD && sq % EDGE_W < BOARD && !blocked[depth][sq]) hit = sq;
      end
      if (hit >= 0) begin
        pick[depth] = hit;
        if (depth + 1 >= need) begin
          answer    = 1'b1;
          searching = 1'b0;
        end else begin
          blocked[depth+1] = blocked[depth] | threat_mask(hit / EDGE_W, hit % EDGE_W);
          depth++;
          scan = hit + 1;
        end
      end else if (depth == 0) begin
        searching = 1'b0;
      end else begin
        depth--;
        scan = pick[depth] + 1;
      end
    end
    return answer;
  endfunction

  // Random symmetry of a known solution, each queen kept with the given percentage
  function automatic logic [63:0] solution_subset(input int keep_pct);
    int          cols [BOARD];
    logic [63:0] m;
    int          r;
    int          c;
    int          t;
    bit          swap_rc;
    bit          flip_r;
    bit          flip_c;
    cols    = '{0, 4, 7, 5, 2, 6, 1, 3};
    swap_rc = $urandom_range(0, 1);
    flip_r  = $urandom_range(0, 1);
    flip_c  = $urandom_range(0, 1);
    m       = '0;
    for (int k = 0; k < BOARD; k++) begin
      r = k;
      c = cols[k];
      if (swap_rc) begin
        t = r;
        r = c;
        c = t;
      end
      if (flip_r) r = BOARD - 1 - r;
      if (flip_c) c = BOARD - 1 - c;
      if ($urandom_range(0, 99) < keep_pct) m[r*EDGE_W+c] = 1'b1;
    end
    return m;
  endfunction

  task automatic push_board(input logic [63:0] board, input bit drain_first);
    board_req_t req;
    req.board       = board;
    req.drain_first = drain_first;
    board_queue.push_back(req);
  endtask

  // Driver: take an accepted request, then offer the next one or idle
  always @(posedge clk) begin
    bit next_valid;
    next_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        solvable_expected.push_back(board_completable(preset_queens));
        accepted_count++;
        next_valid = 1'b0;
        if (accepted_count + TAIL_ITEMS < total_boards && $urandom_range(0, 99) < 30)
          send_gap = $urandom_range(1, 17);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (board_queue.size() > 0) begin
          if (!(board_queue[0].drain_first && solvable_expected.size() != 0)) begin
            preset_queens <= board_queue[0].board;
            next_valid = 1'b1;
            void'(board_queue.pop_front());
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // Monitor: check each result against the oldest prediction, pace ready
  always @(posedge clk) begin
    bit next_ready;
    bit want;
    next_ready = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (solvable_expected.size() == 0) begin
          orphan_count++;
          if (mismatch_count + orphan_count <= MAX_SHOWN)
            $display("[%0t] result %0d arrived with nothing pending", $time, solvable);
        end else begin
          want = solvable_expected.pop_front();
          if (want) solvable_seen++;
          if (solvable !== want) begin
            mismatch_count++;
            if (mismatch_count + orphan_count <= MAX_SHOWN)
              $display("[%0t] solvable mismatch: expected %0d, got %0d", $time, want, solvable);
          end
        end
      end
      // Hold off once for a long stretch so the block backs up its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done   = 1'b1;
        hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else if (accepted_count + TAIL_ITEMS < total_boards &&
                   $urandom_range(0, 99) < 20) begin
        recv_gap = $urandom_range(0, 16);
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready <= next_ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [63:0] board;
    logic [63:0] covered;
    int          sel;
    int          k;
    int          sq;
    int          tries;

    // Directed: empty, full, solutions, conflicts, count limits, corners
    push_board(64'h0, 1'b0);
    push_board('1, 1'b0);
    push_board(solution_subset(100), 1'b0);
    push_board(solution_subset(75), 1'b0);
    push_board(64'h0000_0000_0000_00ff, 1'b0);        // row full: eight in conflict
    push_board(64'h0000_0000_0000_01ff, 1'b0);        // nine presets
    push_board(64'h8040_2010_0804_0201, 1'b0);        // main diagonal, eight in conflict
    push_board(64'h0102_0408_1020_4080, 1'b0);        // anti diagonal
    push_board(64'h0000_0000_0000_0001, 1'b0);
    push_board(64'h8000_0000_0000_0000, 1'b0);
    push_board(64'h0000_0000_0000_0080, 1'b0);
    push_board(64'h0100_0000_0000_0000, 1'b0);
    push_board(64'h8100_0000_0000_0081, 1'b0);        // four corners
    push_board(64'h0000_0000_0000_0003, 1'b0);        // same row
    push_board(64'h0000_0000_0000_0401, 1'b0);        // knight apart
    push_board(64'h0101_0101_0101_0101, 1'b0);        // column full
    push_board(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    push_board(64'h5555_5555_5555_5555, 1'b0);
    push_board(64'h0000_0000_0000_ffff, 1'b0);        // count saturates
    push_board(64'h0000_0000_0000_7fff, 1'b0);
    push_board(64'h0000_0000_0010_0000, 1'b1);        // lone queen on row 2, column 4 after a drain

    // Random: mostly partial placements, then conflicts, count edges and noise
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel   = $urandom_range(0, 99);
      board = '0;
      if (sel < 45) begin
        board = solution_subset($urandom_range(0, 100));
      end else if (sel < 70) begin
        k       = $urandom_range(0, BOARD);
        covered = '0;
        tries   = 0;
        while (k > 0 && tries < 200) begin
          sq = $urandom_range(0, 63);
          if (!covered[sq]) begin
            board[sq] = 1'b1;
            covered  |= threat_mask(sq / EDGE_W, sq % EDGE_W);
            k--;
          end
          tries++;
        end
      end else if (sel < 82) begin
        k = $urandom_range(1, 4);
        for (int q = 0; q < k; q++) board[$urandom_range(0, 63)] = 1'b1;
      end else if (sel < 90) begin
        k = $urandom_range(BOARD, BOARD + 1);
        while ($countones(board) < k) board[$urandom_range(0, 63)] = 1'b1;
      end else begin
        board = {$urandom, $urandom};
      end
      push_board(board, $urandom_range(0, 49) == 0);
    end
    total_boards = board_queue.size();

    // Reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain
    while (accepted_count < total_boards) @(posedge clk);
    while (solvable_expected.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Ran %0d boards, %0d results checked (%0d solvable), %0d mismatches, %0d stray",
             accepted_count, results_seen, solvable_seen, mismatch_count, orphan_count);
    $display("Covered empty, full and overfull boards, conflicting presets, a long output stall");
    if (mismatch_count == 0 && orphan_count == 0 && solvable_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
